/* sv/cht_pkg.sv */
// Package: types and constants for the cuckoo hash table engine.
package cht_pkg;

	localparam int ADDR_BITS = 10;
	localparam int CANDS_BITS = 3 * ADDR_BITS;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_READ   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FAILED   = 2'd1,
		ST_REMOVED  = 2'd2,
		ST_READ     = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		REG_NUM_HASH  = 1'd0,
		REG_MAX_KICKS = 1'd1
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_EVICT_RD,
		S_EVICT_WR,
		S_REM_RD,
		S_REM_CHK,
		S_READ_RD,
		S_READ_DONE,
		S_OUT
	} state_t;

	localparam logic [1:0] POS_STEP = 2'h1;

endpackage

/* sv/cht_if.sv */
// Interfaces: input item channel and result channel.
interface cht_in_if #(
	parameter int VALUE_BITS = 32,
	parameter int ID_BITS = 16
);
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [ID_BITS-1:0] elem_id;
	logic [VALUE_BITS-1:0] value;
	logic [cht_pkg::ADDR_BITS-1:0] addr0;
	logic [cht_pkg::ADDR_BITS-1:0] addr1;
	logic [cht_pkg::ADDR_BITS-1:0] addr2;
	logic [cht_pkg::ADDR_BITS-1:0] read_bin;
	modport source (output valid, kind, elem_id, value, addr0, addr1, addr2, read_bin,
		input ready);
	modport sink (input valid, kind, elem_id, value, addr0, addr1, addr2, read_bin,
		output ready);
endinterface

interface cht_out_if #(
	parameter int VALUE_BITS = 32,
	parameter int ID_BITS = 16
);
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [ID_BITS-1:0] homeless_id;
	logic [15:0] kicks_used;
	logic [1:0] cleared;
	logic bin_full;
	logic [ID_BITS-1:0] bin_elem_id;
	logic [VALUE_BITS-1:0] bin_value;
	logic [1:0] bin_slot;
	modport source (output valid, status, homeless_id, kicks_used, cleared, bin_full,
		bin_elem_id, bin_value, bin_slot, input ready);
	modport sink (input valid, status, homeless_id, kicks_used, cleared, bin_full,
		bin_elem_id, bin_value, bin_slot, output ready);
endinterface

/* sv/cht_mem.sv */
// Bin memory: payload array plus valid array, one port each, registered reads.
module cht_mem #(
	parameter int NUM_BINS = 1024,
	parameter int W = 80,
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic [AW-1:0] addr,
	input  logic          we,
	input  logic [W-1:0]  wdata,
	input  logic          vwe,
	input  logic          vwdata,
	output logic [W-1:0]  rdata,
	output logic          rvalid
);
	logic [W-1:0] mem [NUM_BINS];
	logic vmem [NUM_BINS];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (vwe)
			vmem[addr] <= vwdata;
		rvalid <= vmem[addr];
	end
endmodule

/* sv/cuckoo_hash_table_insert.sv */
// Top level: cuckoo hash table insert, remove and read engine.
// channel | dir | carries
// in      | in  | kind, elem_id, value, addr0..2, read_bin
// out     | out | status, homeless_id, kicks_used, cleared, bin_full, bin fields
// cfg     | in  | cfg_we, cfg_idx, cfg_data (num_hash, max_kicks)
// After reset a clearing pass over all NUM_BINS bins empties the valid array; in.ready is low.
// Insert: read and check per candidate; read and write per eviction (one memory port).
// Remove: read and check per candidate; read: one bin read and captured; result in S_OUT.
// One item at a time; the result register holds until out.ready.
module cuckoo_hash_table_insert #(
	parameter int NUM_BINS = 1024,
	parameter int VALUE_BITS = 32,
	parameter int ID_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	cht_in_if.sink      in,
	cht_out_if.source   out,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_data
);
	localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int CB = cht_pkg::CANDS_BITS;
	localparam int W = ID_BITS + VALUE_BITS + 2 + CB;

	cht_pkg::state_t st_q, st_d;
	logic [1:0] num_hash_q;
	logic [15:0] max_kicks_q;
	logic [AW:0] clr_q;

	logic [1:0] kind_q;
	logic [ID_BITS-1:0] id_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CB-1:0] cands_q;
	logic [1:0] pos_q, i_q, slot_q;
	logic [15:0] k_q;
	logic [1:0] cnt_q;
	logic [AW-1:0] rbin_q;
	logic three;

	logic [AW-1:0] maddr;
	logic mwe, vwe, vwd;
	logic [W-1:0] wdata, rdata;
	logic rvalid;

	cht_mem #(.NUM_BINS(NUM_BINS), .W(W), .AW(AW)) u_mem (
		.clk, .addr(maddr), .we(mwe), .wdata, .vwe, .vwdata(vwd), .rdata, .rvalid);

	assign three = (num_hash_q == 2'd3);

	function automatic logic [AW-1:0] cand(input logic [CB-1:0] c, input logic [1:0] i);
		logic [cht_pkg::ADDR_BITS-1:0] a;
		case (i)
			2'd0: a = c[9:0];
			2'd1: a = c[19:10];
			default: a = c[29:20];
		endcase
		return AW'(a % NUM_BINS);
	endfunction

	logic [ID_BITS-1:0] r_id;
	logic [VALUE_BITS-1:0] r_val;
	logic [1:0] r_pos;
	logic [CB-1:0] r_cands;
	assign {r_id, r_val, r_pos, r_cands} = rdata;

	logic last_i;
	assign last_i = three ? (i_q == 2'd2) : (i_q == 2'd1);
	logic [1:0] ev_pos;
	assign ev_pos = (pos_q == 2'd2) ? 2'd0 : pos_q + cht_pkg::POS_STEP;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			cht_pkg::S_CLEAR: if (clr_q == (AW+1)'(NUM_BINS - 1)) st_d = cht_pkg::S_IDLE;
			cht_pkg::S_IDLE: if (in.valid) begin
				unique case (cht_pkg::kind_t'(in.kind))
					cht_pkg::KIND_INSERT: st_d = cht_pkg::S_PROBE_RD;
					cht_pkg::KIND_REMOVE: st_d = cht_pkg::S_REM_RD;
					cht_pkg::KIND_READ:   st_d = cht_pkg::S_READ_RD;
					default:              st_d = cht_pkg::S_IDLE;
				endcase
			end
			cht_pkg::S_PROBE_RD: st_d = (k_q == max_kicks_q) ? cht_pkg::S_OUT
				: cht_pkg::S_PROBE_CHK;
			cht_pkg::S_PROBE_CHK:
				if (!rvalid) st_d = cht_pkg::S_OUT;
				else if (last_i) st_d = cht_pkg::S_EVICT_RD;
				else st_d = cht_pkg::S_PROBE_RD;
			cht_pkg::S_EVICT_RD: st_d = cht_pkg::S_EVICT_WR;
			cht_pkg::S_EVICT_WR: st_d = cht_pkg::S_PROBE_RD;
			cht_pkg::S_REM_RD: st_d = cht_pkg::S_REM_CHK;
			cht_pkg::S_REM_CHK: st_d = last_i ? cht_pkg::S_OUT : cht_pkg::S_REM_RD;
			cht_pkg::S_READ_RD: st_d = cht_pkg::S_READ_DONE;
			cht_pkg::S_READ_DONE: st_d = cht_pkg::S_OUT;
			cht_pkg::S_OUT: if (out.ready) st_d = cht_pkg::S_IDLE;
			default: st_d = cht_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		maddr = cand(cands_q, i_q);
		mwe = 1'b0;
		vwe = 1'b0;
		vwd = 1'b0;
		wdata = {id_q, val_q, i_q, cands_q};
		unique case (st_q)
			cht_pkg::S_CLEAR: begin
				maddr = clr_q[AW-1:0];
				vwe = 1'b1;
			end
			cht_pkg::S_PROBE_CHK: if (!rvalid) begin
				mwe = 1'b1;
				vwe = 1'b1;
				vwd = 1'b1;
			end
			cht_pkg::S_EVICT_RD: maddr = cand(cands_q, slot_q);
			cht_pkg::S_EVICT_WR: begin
				maddr = cand(cands_q, slot_q);
				mwe = 1'b1;
				vwe = 1'b1;
				vwd = 1'b1;
				wdata = {id_q, val_q, slot_q, cands_q};
			end
			cht_pkg::S_REM_CHK: if (rvalid && r_val == val_q) vwe = 1'b1;
			cht_pkg::S_READ_RD, cht_pkg::S_READ_DONE: maddr = rbin_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cht_pkg::S_CLEAR;
			clr_q <= '0;
			num_hash_q <= 2'd2;
			max_kicks_q <= 16'd1024;
		end else begin
			st_q <= st_d;
			if (st_q == cht_pkg::S_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (cfg_we) begin
				unique case (cht_pkg::reg_idx_t'(cfg_idx))
					cht_pkg::REG_NUM_HASH:  num_hash_q <= cfg_data[1:0];
					cht_pkg::REG_MAX_KICKS: max_kicks_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			cht_pkg::S_IDLE: begin
				kind_q <= in.kind;
				id_q <= in.elem_id;
				val_q <= in.value;
				cands_q <= {in.addr2, in.addr1, in.addr0};
				rbin_q <= AW'(in.read_bin % NUM_BINS);
				pos_q <= 2'd0;
				i_q <= 2'd0;
				k_q <= '0;
				cnt_q <= '0;
			end
			cht_pkg::S_PROBE_CHK: if (rvalid) begin
				i_q <= last_i ? 2'd0 : i_q + 1'b1;
				if (last_i) begin
					slot_q <= three ? ev_pos : {1'b0, pos_q[0]};
					if (three) pos_q <= ev_pos;
				end
			end
			cht_pkg::S_EVICT_WR: begin
				id_q <= r_id;
				val_q <= r_val;
				cands_q <= r_cands;
				pos_q <= three ? ((r_pos == 2'd2) ? 2'd0 : r_pos + 1'b1)
					: ((r_pos == 2'd1) ? 2'd0 : 2'd1);
				k_q <= k_q + 1'b1;
			end
			cht_pkg::S_REM_CHK: begin
				i_q <= i_q + 1'b1;
				if (rvalid && r_val == val_q) cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	logic fail;
	always_ff @(posedge clk) begin
		if (st_q == cht_pkg::S_PROBE_RD) fail <= (k_q == max_kicks_q);
		if (st_q == cht_pkg::S_PROBE_CHK) fail <= 1'b0;
	end

	always_comb begin
		in.ready = (st_q == cht_pkg::S_IDLE);
		out.valid = (st_q == cht_pkg::S_OUT);
		out.status = cht_pkg::ST_READ;
		out.homeless_id = '0;
		out.kicks_used = '0;
		out.cleared = '0;
		unique case (cht_pkg::kind_t'(kind_q))
			cht_pkg::KIND_INSERT: begin
				out.status = fail ? cht_pkg::ST_FAILED : cht_pkg::ST_INSERTED;
				out.homeless_id = fail ? id_q : '0;
				out.kicks_used = k_q;
			end
			cht_pkg::KIND_REMOVE: begin
				out.status = cht_pkg::ST_REMOVED;
				out.cleared = cnt_q;
			end
			default: ;
		endcase
	end

	logic rd_full_q;
	logic [W-1:0] rd_q;
	always_ff @(posedge clk) begin
		if (st_q == cht_pkg::S_READ_DONE) begin
			rd_full_q <= rvalid;
			rd_q <= rdata;
		end
	end
	logic is_rd;
	assign is_rd = (kind_q == cht_pkg::KIND_READ) && rd_full_q;
	assign out.bin_full = is_rd;
	assign out.bin_elem_id = is_rd ? rd_q[W-1 -: ID_BITS] : '0;
	assign out.bin_value = is_rd ? rd_q[CB+2 +: VALUE_BITS] : '0;
	assign out.bin_slot = is_rd ? rd_q[CB +: 2] : '0;

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in.ready |-> !out.valid) else $error("ready while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid) else $error("result dropped");
	a_kicks: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && kind_q == cht_pkg::KIND_INSERT |-> k_q <= max_kicks_q)
		else $error("kicks over limit");
	a_no_clr_write: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == cht_pkg::S_CLEAR |-> !mwe && !in.ready) else $error("access in clear");
`endif
endmodule
